// File: rtl/core/mtpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtpc_pkg
// Shared types and constants of the two-point moisture calibrator.
// ----------------------------------------------------------------------------
package mtpc_pkg;

    // fixed field widths
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int PT_W    = 10;
    localparam int LEVEL_W = 16;
    localparam int PHASE_W = 3;
    localparam int HOLD_W  = 17;
    localparam int CIDX_W  = 3;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 17'h1FFFF;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_MEAS       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_AIR        = 3'd1;
    localparam logic [PHASE_W-1:0] PH_AIR_DONE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WATER      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WATER_DONE = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MEAS_INT   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CAL_INT    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_START_HOLD = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_NEXT_HOLD  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_AIR_DEF    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_WATER_DEF  = 3'd5;

    // reset values
    localparam logic [CFG_W-1:0] RST_MEAS_INT   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_CAL_INT    = 16'd100;
    localparam logic [CFG_W-1:0] RST_START_HOLD = 16'd1000;
    localparam logic [CFG_W-1:0] RST_NEXT_HOLD  = 16'd1000;
    localparam logic [PT_W-1:0]  RST_AIR_DEF    = 10'd1023;
    localparam logic [PT_W-1:0]  RST_WATER_DEF  = 10'd0;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP1 = 5'b00010,
        ST_PREP2 = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

// File: rtl/core/mtpc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtpc_in_if
// Polling pass request channel: time, button level and probe sample.
// ----------------------------------------------------------------------------
interface mtpc_in_if #(
    parameter int ADC_BITS = 10
) ();
    logic                      valid;
    logic                      ready;
    logic [mtpc_pkg::TIME_W-1:0] now_ms;
    logic                      btn_down;
    logic [ADC_BITS-1:0]       adc_sample;

    modport source (output valid, output now_ms, output btn_down,
                    output adc_sample, input ready);
    modport sink   (input valid, input now_ms, input btn_down,
                    input adc_sample, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mtpc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtpc_out_if
// Result channel: mapped level, status and calibration points of one pass.
// ----------------------------------------------------------------------------
interface mtpc_out_if ();
    logic                                valid;
    logic                                ready;
    logic                                level_valid;
    logic signed [mtpc_pkg::LEVEL_W-1:0] moisture_level;
    logic                                map_error;
    logic [mtpc_pkg::PHASE_W-1:0]        phase;
    logic [mtpc_pkg::PT_W-1:0]           air_point;
    logic [mtpc_pkg::PT_W-1:0]           water_point;
    logic                                store_request;

    modport source (output valid, output level_valid, output moisture_level,
                    output map_error, output phase, output air_point,
                    output water_point, output store_request, input ready);
    modport sink   (input valid, input level_valid, input moisture_level,
                    input map_error, input phase, input air_point,
                    input water_point, input store_request, output ready);
endinterface
`default_nettype wire

// File: rtl/core/moisture_two_point_calibrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moisture_two_point_calibrator
// Two-point soil moisture calibrator with button-driven air/water averaging.
// ----------------------------------------------------------------------------
// Usage:
//  i_in_ch carries one polling pass request (now_ms, btn_down,
//  adc_sample); o_out_ch returns exactly one result per pass. Config is a
//  plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata), written while
//  the block is idle; writing an air/water default also loads that point.
//  An accepted pass steps through PREP1, PREP2 and FIN, where the result is
//  registered; a pass that maps a level over a nonzero span or closes a
//  calibration average also runs the divider in DIV before FIN. NW =
//  max(ADC_BITS + 7, sum width) is the bit count of the shared restoring
//  divider. Ready returns together with the registered result.
//  One pass is processed at a time; ready is high only when the sequencer
//  is idle. The result register lets the next request enter while a result
//  waits; a stalled receiver holds that result and the next pass waits in
//  its final step until the result is taken.
//  Reset (synchronous, active low) loads the register defaults, returns to
//  measuring phase and clears timers, counters and the result valid flag.
// ----------------------------------------------------------------------------
module moisture_two_point_calibrator #(
    parameter int CAL_READINGS = 16,
    parameter int ADC_BITS     = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [mtpc_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire [mtpc_pkg::CFG_W-1:0]    i_cfg_wdata,
    mtpc_in_if.sink                      i_in_ch,
    mtpc_out_if.source                   o_out_ch
);
    localparam int A    = ADC_BITS;
    localparam int CNTW = $clog2(CAL_READINGS + 1);
    localparam int SUMW = A + CNTW;
    localparam int NW   = (A + 7 > SUMW) ? A + 7 : SUMW;
    localparam int DW   = (A > CNTW) ? A : CNTW;
    localparam int LVW  = NW + 2;
    localparam int TW   = mtpc_pkg::TIME_W;

    localparam logic signed [LVW-1:0] LV_MAX     = LVW'(32767);
    localparam logic signed [LVW-1:0] LV_MIN     = LVW'(-32768);
    localparam logic signed [LVW-1:0] LV_HUNDRED = LVW'(100);

    // configuration
    logic [mtpc_pkg::CFG_W-1:0] r_meas_int;
    logic [mtpc_pkg::CFG_W-1:0] r_cal_int;
    logic [mtpc_pkg::CFG_W-1:0] r_start_hold;
    logic [mtpc_pkg::CFG_W-1:0] r_next_hold;

    // block state
    mtpc_pkg::t_state              r_state;
    logic [mtpc_pkg::PHASE_W-1:0]  r_phase;
    logic [TW-1:0]                 r_next_run;
    logic [mtpc_pkg::HOLD_W-1:0]   r_hold;
    logic [SUMW-1:0]               r_sum;
    logic [CNTW-1:0]               r_cnt;
    logic [A-1:0]                  r_air;
    logic [A-1:0]                  r_water;

    // captured pass and precomputed compares
    logic [TW-1:0] r_now;
    logic          r_btn;
    logic [A-1:0]  r_adc;
    logic          r_gt_old;
    logic          r_gt_m;
    logic          r_gt_c;
    logic [TW-1:0] r_m_next;
    logic [TW-1:0] r_c_next;
    logic          r_map_go;
    logic          r_span_zero;
    logic          r_neg;

    // result register
    logic                                r_out_valid;
    logic                                r_o_level_valid;
    logic signed [mtpc_pkg::LEVEL_W-1:0] r_o_level;
    logic                                r_o_err;
    logic [mtpc_pkg::PHASE_W-1:0]        r_o_phase;
    logic [mtpc_pkg::PT_W-1:0]           r_o_air;
    logic [mtpc_pkg::PT_W-1:0]           r_o_water;
    logic                                r_o_store;

    // divider
    mtpc_pkg::t_div_ctl  w_div_ctl;
    mtpc_pkg::t_div_stat w_div_stat;
    logic [NW-1:0]       w_dividend;
    logic [DW-1:0]       w_divisor;
    logic [NW-1:0]       w_quo;

    // prep2 operands
    logic signed [A:0] w_d;
    logic signed [A:0] w_span;
    logic [A-1:0]      w_dmag;
    logic [A-1:0]      w_smag;
    logic [NW-1:0]     w_dm;
    logic              w_map_go;
    logic              w_avg_go;
    logic              w_need_div;

    // pass results
    logic [mtpc_pkg::PHASE_W-1:0]        n_phase;
    logic [TW-1:0]                       n_next_run;
    logic [mtpc_pkg::HOLD_W-1:0]         n_hold;
    logic [SUMW-1:0]                     n_sum;
    logic [CNTW-1:0]                     n_cnt;
    logic [A-1:0]                        n_air;
    logic [A-1:0]                        n_water;
    logic                                n_level_valid;
    logic signed [mtpc_pkg::LEVEL_W-1:0] n_level;
    logic                                n_err;
    logic                                n_store;
    mtpc_pkg::t_state                    n_state;

    logic w_out_free;

    assign i_in_ch.ready = (r_state == mtpc_pkg::ST_IDLE);
    assign w_out_free    = !r_out_valid || o_out_ch.ready;

    // ---------------- division setup ----------------
    always_comb begin
        w_d    = $signed({1'b0, r_adc}) - $signed({1'b0, r_water});
        w_span = $signed({1'b0, r_air}) - $signed({1'b0, r_water});
        w_dmag = w_d[A]    ? A'(-w_d)    : w_d[A-1:0];
        w_smag = w_span[A] ? A'(-w_span) : w_span[A-1:0];
        w_dm   = NW'(w_dmag);
        w_map_go = r_gt_old && (r_phase == mtpc_pkg::PH_MEAS);
        // an average closes only when sampling was under way at pass start
        w_avg_go = r_gt_old && (r_cnt >= CNTW'(CAL_READINGS)) &&
                   ((r_phase == mtpc_pkg::PH_AIR) || (r_phase == mtpc_pkg::PH_WATER));
        w_need_div = (w_map_go && (r_air != r_water)) || w_avg_go;
        if (w_map_go) begin
            w_dividend = (w_dm << 6) + (w_dm << 5) + (w_dm << 2);
            w_divisor  = DW'(w_smag);
        end else begin
            w_dividend = NW'(r_sum);
            w_divisor  = DW'(CAL_READINGS);
        end
        w_div_ctl.start = (r_state == mtpc_pkg::ST_PREP2) && w_need_div;
    end

    mtpc_divider #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // ---------------- pass update ----------------
    always_comb begin
        logic                 gt;
        logic signed [LVW-1:0] qs;
        logic signed [LVW-1:0] v;

        n_phase       = r_phase;
        n_next_run    = r_next_run;
        n_hold        = r_hold;
        n_sum         = r_sum;
        n_cnt         = r_cnt;
        n_air         = r_air;
        n_water       = r_water;
        n_level_valid = 1'b0;
        n_level       = '0;
        n_err         = 1'b0;
        n_store       = 1'b0;
        gt            = r_gt_old;

        qs = $signed({2'b00, w_quo});
        if (r_neg) begin
            qs = -qs;
        end
        v = qs + LV_HUNDRED;

        if (r_map_go) begin
            n_next_run    = r_m_next;
            gt            = r_gt_m;
            n_level_valid = 1'b1;
            if (r_span_zero) begin
                n_err = 1'b1;
            end else if (v > LV_MAX) begin
                n_level = 16'sh7FFF;
            end else if (v < LV_MIN) begin
                n_level = 16'sh8000;
            end else begin
                n_level = v[mtpc_pkg::LEVEL_W-1:0];
            end
        end

        if (r_btn) begin
            if (r_hold != mtpc_pkg::HOLD_MAX) begin
                n_hold = r_hold + 1'b1;
            end
        end else begin
            n_hold = '0;
        end

        if ((n_hold > {1'b0, r_start_hold}) && (n_phase == mtpc_pkg::PH_MEAS)) begin
            n_hold  = '0;
            n_sum   = '0;
            n_cnt   = '0;
            n_phase = mtpc_pkg::PH_AIR;
        end
        if (gt && (n_phase == mtpc_pkg::PH_AIR)) begin
            n_next_run = r_c_next;
            gt         = r_gt_c;
            if (n_cnt < CNTW'(CAL_READINGS)) begin
                n_sum = n_sum + SUMW'(r_adc);
                n_cnt = n_cnt + 1'b1;
            end else begin
                n_air      = w_quo[A-1:0];
                n_phase    = mtpc_pkg::PH_AIR_DONE;
                n_next_run = '0;
                gt         = (r_now != '0);
            end
        end

        if ((n_hold > {1'b0, r_next_hold}) && (n_phase == mtpc_pkg::PH_AIR_DONE)) begin
            n_hold  = '0;
            n_sum   = '0;
            n_cnt   = '0;
            n_phase = mtpc_pkg::PH_WATER;
        end
        if (gt && (n_phase == mtpc_pkg::PH_WATER)) begin
            n_next_run = r_c_next;
            if (n_cnt < CNTW'(CAL_READINGS)) begin
                n_sum = n_sum + SUMW'(r_adc);
                n_cnt = n_cnt + 1'b1;
            end else begin
                n_water    = w_quo[A-1:0];
                n_phase    = mtpc_pkg::PH_WATER_DONE;
                n_next_run = '0;
            end
        end

        if (n_phase == mtpc_pkg::PH_WATER_DONE) begin
            n_store = 1'b1;
            n_phase = mtpc_pkg::PH_MEAS;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtpc_pkg::ST_IDLE: begin
                if (i_in_ch.valid) begin
                    n_state = mtpc_pkg::ST_PREP1;
                end
            end
            mtpc_pkg::ST_PREP1: n_state = mtpc_pkg::ST_PREP2;
            mtpc_pkg::ST_PREP2: begin
                n_state = w_need_div ? mtpc_pkg::ST_DIV : mtpc_pkg::ST_FIN;
            end
            mtpc_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = mtpc_pkg::ST_FIN;
                end
            end
            mtpc_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = mtpc_pkg::ST_IDLE;
                end
            end
            default: n_state = mtpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mtpc_pkg::ST_IDLE;
            r_meas_int   <= mtpc_pkg::RST_MEAS_INT;
            r_cal_int    <= mtpc_pkg::RST_CAL_INT;
            r_start_hold <= mtpc_pkg::RST_START_HOLD;
            r_next_hold  <= mtpc_pkg::RST_NEXT_HOLD;
            r_phase      <= mtpc_pkg::PH_MEAS;
            r_next_run   <= '0;
            r_hold       <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_air        <= A'(mtpc_pkg::RST_AIR_DEF);
            r_water      <= A'(mtpc_pkg::RST_WATER_DEF);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= ((r_state == mtpc_pkg::ST_FIN) && w_out_free) ||
                           (r_out_valid && !o_out_ch.ready);
            if ((r_state == mtpc_pkg::ST_FIN) && w_out_free) begin
                r_phase     <= n_phase;
                r_next_run  <= n_next_run;
                r_hold      <= n_hold;
                r_sum       <= n_sum;
                r_cnt       <= n_cnt;
                r_air       <= n_air;
                r_water     <= n_water;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mtpc_pkg::CFG_MEAS_INT:   r_meas_int   <= i_cfg_wdata;
                    mtpc_pkg::CFG_CAL_INT:    r_cal_int    <= i_cfg_wdata;
                    mtpc_pkg::CFG_START_HOLD: r_start_hold <= i_cfg_wdata;
                    mtpc_pkg::CFG_NEXT_HOLD:  r_next_hold  <= i_cfg_wdata;
                    mtpc_pkg::CFG_AIR_DEF:    r_air   <= A'(i_cfg_wdata[mtpc_pkg::PT_W-1:0]);
                    mtpc_pkg::CFG_WATER_DEF:  r_water <= A'(i_cfg_wdata[mtpc_pkg::PT_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            mtpc_pkg::ST_IDLE: begin
                r_now <= i_in_ch.now_ms;
                r_btn <= i_in_ch.btn_down;
                r_adc <= i_in_ch.adc_sample;
            end
            mtpc_pkg::ST_PREP1: begin
                r_gt_old <= (r_now > r_next_run);
                r_m_next <= r_now + TW'(r_meas_int);
                r_c_next <= r_now + TW'(r_cal_int);
            end
            mtpc_pkg::ST_PREP2: begin
                r_gt_m      <= (r_now > r_m_next);
                r_gt_c      <= (r_now > r_c_next);
                r_map_go    <= w_map_go;
                r_span_zero <= (r_air == r_water);
                // level is scaled by -100, so same signs give a negative quotient
                r_neg       <= (w_d[A] == w_span[A]);
            end
            mtpc_pkg::ST_FIN: begin
                if (w_out_free) begin
                    r_o_level_valid <= n_level_valid;
                    r_o_level       <= n_level;
                    r_o_err         <= n_err;
                    r_o_phase       <= n_phase;
                    r_o_air         <= mtpc_pkg::PT_W'(n_air);
                    r_o_water       <= mtpc_pkg::PT_W'(n_water);
                    r_o_store       <= n_store;
                end
            end
            default: ;
        endcase
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.level_valid    = r_o_level_valid;
    assign o_out_ch.moisture_level = r_o_level;
    assign o_out_ch.map_error      = r_o_err;
    assign o_out_ch.phase          = r_o_phase;
    assign o_out_ch.air_point      = r_o_air;
    assign o_out_ch.water_point    = r_o_water;
    assign o_out_ch.store_request  = r_o_store;

`ifndef ASSERT_OFF
    a_no_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_phase != mtpc_pkg::PH_WATER_DONE))
        else $error("water-done phase left in a result");

    a_store_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_store) |-> ((r_o_phase == mtpc_pkg::PH_MEAS) && !r_o_level_valid))
        else $error("store request outside the closing pass");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_err) |-> (r_o_level_valid && (r_o_level == '0)))
        else $error("map error with a nonzero level");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtpc_pkg::ST_IDLE) |-> !w_div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_div_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mtpc_pkg::ST_DIV) && w_div_stat.done) |=> (r_state == mtpc_pkg::ST_FIN))
        else $error("division done but pass not finished");
`endif

endmodule
`default_nettype wire

// File: rtl/core/mtpc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtpc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtpc_divider #(
    parameter int NW = 17,
    parameter int DW = 10
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mtpc_pkg::t_div_ctl   i_ctl,
    input  wire [NW-1:0]         i_dividend,
    input  wire [DW-1:0]         i_divisor,
    output mtpc_pkg::t_div_stat  o_stat,
    output logic [NW-1:0]        o_quotient
);
    localparam int CTW = $clog2(NW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CTW-1:0] r_cnt;
    logic [DW:0]    r_rem;
    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_dsr;

    logic [DW:0]    w_shift;
    logic [DW:0]    w_diff;
    logic           w_fit;

    always_comb begin
        w_shift = {r_rem[DW-1:0], r_quo[NW-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        w_fit   = (w_shift >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff : w_shift;
            r_quo <= {r_quo[NW-2:0], w_fit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
`default_nettype wire
